// ===== rtl/core/cssg_pkg.sv =====
package cssg_pkg;

    localparam int DATA_W    = 8;
    localparam int LEN_W     = 7;
    localparam int PC_W      = 5;
    localparam int MOD_STEPS = DATA_W;
    localparam int MODCNT_W  = $clog2(MOD_STEPS + 1);

    localparam logic [DATA_W-1:0] LIGHTS_RESET = 8'd8;
    localparam logic [DATA_W-1:0] LIGHTS_MIN   = 8'd3;
    localparam logic [LEN_W-1:0]  SUBSET_RESET = 7'd3;
    localparam logic [LEN_W-1:0]  SUBSET_MIN   = 7'd3;
    localparam logic [LEN_W-1:0]  SUBSET_MAX   = 7'd64;

    // configuration register indexes
    localparam logic REG_LIGHT_COUNT   = 1'b0;
    localparam logic REG_SUBSET_LENGTH = 1'b1;

    // microprogram step addresses
    localparam logic [PC_W-1:0] ST_WAIT       = 5'd0;
    localparam logic [PC_W-1:0] ST_MOD_IDX    = 5'd1;
    localparam logic [PC_W-1:0] ST_WAIT_IDX   = 5'd2;
    localparam logic [PC_W-1:0] ST_WB_IDX     = 5'd3;
    localparam logic [PC_W-1:0] ST_MOD_STR    = 5'd4;
    localparam logic [PC_W-1:0] ST_WAIT_STR   = 5'd5;
    localparam logic [PC_W-1:0] ST_WB_STR     = 5'd6;
    localparam logic [PC_W-1:0] ST_MOD_CNT    = 5'd7;
    localparam logic [PC_W-1:0] ST_WAIT_CNT   = 5'd8;
    localparam logic [PC_W-1:0] ST_WB_CNT     = 5'd9;
    localparam logic [PC_W-1:0] ST_COUNT      = 5'd10;
    localparam logic [PC_W-1:0] ST_STRIDE     = 5'd11;
    localparam logic [PC_W-1:0] ST_GCD_TEST   = 5'd12;
    localparam logic [PC_W-1:0] ST_MOD_GCD    = 5'd13;
    localparam logic [PC_W-1:0] ST_WAIT_GCD   = 5'd14;
    localparam logic [PC_W-1:0] ST_WB_GCD     = 5'd15;
    localparam logic [PC_W-1:0] ST_COPRIME    = 5'd16;
    localparam logic [PC_W-1:0] ST_EXH        = 5'd17;
    localparam logic [PC_W-1:0] ST_EMIT       = 5'd18;
    localparam logic [PC_W-1:0] ST_DONE       = 5'd19;
    localparam logic [PC_W-1:0] ST_LOOP       = 5'd20;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MOD_IDX,
        OP_MOD_STR,
        OP_MOD_CNT,
        OP_MOD_GCD,
        OP_WB_IDX,
        OP_WB_STR,
        OP_WB_CNT,
        OP_WB_GCD,
        OP_COUNT,
        OP_STRIDE,
        OP_EXH,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_MOD_BUSY,
        C_CNT_LOW,
        C_GB_ZERO,
        C_GA_NOT_ONE,
        C_OUT_FULL,
        C_LAST_DONE
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } mod_req_t;

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            ST_WAIT:     w = '{OP_LOAD,    C_NO_ACCEPT,  ST_WAIT};
            ST_MOD_IDX:  w = '{OP_MOD_IDX, C_NEVER,      ST_WAIT};
            ST_WAIT_IDX: w = '{OP_NOP,     C_MOD_BUSY,   ST_WAIT_IDX};
            ST_WB_IDX:   w = '{OP_WB_IDX,  C_NEVER,      ST_WAIT};
            ST_MOD_STR:  w = '{OP_MOD_STR, C_NEVER,      ST_WAIT};
            ST_WAIT_STR: w = '{OP_NOP,     C_MOD_BUSY,   ST_WAIT_STR};
            ST_WB_STR:   w = '{OP_WB_STR,  C_NEVER,      ST_WAIT};
            ST_MOD_CNT:  w = '{OP_MOD_CNT, C_NEVER,      ST_WAIT};
            ST_WAIT_CNT: w = '{OP_NOP,     C_MOD_BUSY,   ST_WAIT_CNT};
            ST_WB_CNT:   w = '{OP_WB_CNT,  C_NEVER,      ST_WAIT};
            ST_COUNT:    w = '{OP_COUNT,   C_CNT_LOW,    ST_EMIT};
            ST_STRIDE:   w = '{OP_STRIDE,  C_NEVER,      ST_WAIT};
            ST_GCD_TEST: w = '{OP_NOP,     C_GB_ZERO,    ST_COPRIME};
            ST_MOD_GCD:  w = '{OP_MOD_GCD, C_NEVER,      ST_WAIT};
            ST_WAIT_GCD: w = '{OP_NOP,     C_MOD_BUSY,   ST_WAIT_GCD};
            ST_WB_GCD:   w = '{OP_WB_GCD,  C_ALWAYS,     ST_GCD_TEST};
            ST_COPRIME:  w = '{OP_NOP,     C_GA_NOT_ONE, ST_STRIDE};
            ST_EXH:      w = '{OP_EXH,     C_NEVER,      ST_WAIT};
            ST_EMIT:     w = '{OP_EMIT,    C_OUT_FULL,   ST_EMIT};
            ST_DONE:     w = '{OP_NOP,     C_LAST_DONE,  ST_WAIT};
            ST_LOOP:     w = '{OP_NOP,     C_ALWAYS,     ST_COUNT};
            default:     w = '{OP_NOP,     C_ALWAYS,     ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/cssg_mod_unit.sv =====
module cssg_mod_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cssg_pkg::mod_req_t             req,
    output logic                           busy,
    output logic [cssg_pkg::DATA_W-1:0]    remainder
);

    logic [cssg_pkg::DATA_W-1:0]   rem_reg, rem_next;
    logic [cssg_pkg::DATA_W-1:0]   dvd_reg;
    logic [cssg_pkg::DATA_W-1:0]   dvs_reg;
    logic [cssg_pkg::MODCNT_W-1:0] cnt_reg;
    logic [cssg_pkg::DATA_W:0]     trial;

    // restoring remainder, one dividend bit per cycle
    assign trial = {rem_reg, dvd_reg[cssg_pkg::DATA_W-1]};

    always_comb begin
        if (trial >= {1'b0, dvs_reg}) begin
            rem_next = cssg_pkg::DATA_W'(trial - {1'b0, dvs_reg});
        end else begin
            rem_next = trial[cssg_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (req.start) begin
            cnt_reg <= cssg_pkg::MODCNT_W'(cssg_pkg::MOD_STEPS);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[cssg_pkg::DATA_W-2:0], 1'b0};
        end
    end

    assign busy      = (cnt_reg != '0);
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/coprime_stride_subset_generator.sv =====
// Channel | Dir | Handshake          | Payload
// s_      | in  | s_tvalid/s_tready  | s_tdata[0] restart
// m_      | out | m_tvalid/m_tready  | m_tdata light_index, m_tlast, m_tuser exhausted
// cfg_    | in  | cfg_we             | cfg_index selects register, cfg_data value
//
// One request item yields subset_length result items. Setup does three reductions in the
// shared remainder unit, which sets the long waits; each index runs the count, emit, done
// and loop steps; a stride change adds stride, GCD test and coprime steps per candidate,
// a remainder per Euclid step and the exhausted step. A microcode step retires each cycle.
// Reset (aresetn low, synchronous) restores lights 8, subset 3 and the generator state.
// A full output register holds the sequencer on the emit step; s_tready is high only
// while the sequencer waits for a request.
module coprime_stride_subset_generator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [0] restart, [7:1] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] light_index
    output logic       m_tlast,
    output logic       m_tuser,   // [0] exhausted
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int DW = cssg_pkg::DATA_W;
    localparam int LW = cssg_pkg::LEN_W;

    logic [DW-1:0] lc_reg;
    logic [LW-1:0] sl_reg;
    logic [DW-1:0] n_reg;
    logic [LW-1:0] len_reg;
    logic [DW-1:0] idx_reg, strd_reg, cnt_reg;
    logic          exh_reg;
    logic [LW-1:0] rep_reg;
    logic [DW-1:0] ga_reg, gb_reg;
    logic [cssg_pkg::PC_W-1:0] pc_reg, pc_next;
    logic          m_tvalid_reg;
    logic [DW-1:0] out_idx_reg;
    logic          out_last_reg, out_exh_reg;

    cssg_pkg::uword_t   cw;
    cssg_pkg::mod_req_t mreq;
    logic               mod_busy;
    logic [DW-1:0]      mod_rem;

    logic          s_acc, out_free, take;
    logic [DW:0]   n9, cnt_inc, str_inc, idx_sum;
    logic [DW-1:0] str_wrap, idx_adv, n_clamp;
    logic [LW-1:0] len_clamp;

    assign cw       = cssg_pkg::ucode(pc_reg);
    assign s_tready = (pc_reg == cssg_pkg::ST_WAIT);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign n9      = {1'b0, n_reg};
    assign cnt_inc = {1'b0, cnt_reg} + 9'd1;
    assign str_inc = {1'b0, strd_reg} + 9'd1;
    assign idx_sum = {1'b0, idx_reg} + {1'b0, strd_reg};
    assign str_wrap = (str_inc == n9) ? '0 : str_inc[DW-1:0];
    assign idx_adv  = (idx_sum >= n9) ? DW'(idx_sum - n9) : idx_sum[DW-1:0];

    assign n_clamp = (lc_reg < cssg_pkg::LIGHTS_MIN) ? cssg_pkg::LIGHTS_MIN : lc_reg;

    always_comb begin
        if (sl_reg < cssg_pkg::SUBSET_MIN) begin
            len_clamp = cssg_pkg::SUBSET_MIN;
        end else if (sl_reg > cssg_pkg::SUBSET_MAX) begin
            len_clamp = cssg_pkg::SUBSET_MAX;
        end else begin
            len_clamp = sl_reg;
        end
    end

    // jump condition
    always_comb begin
        case (cw.cond)
            cssg_pkg::C_ALWAYS:     take = 1'b1;
            cssg_pkg::C_NO_ACCEPT:  take = !s_acc;
            cssg_pkg::C_MOD_BUSY:   take = mod_busy;
            cssg_pkg::C_CNT_LOW:    take = (cnt_inc < n9);
            cssg_pkg::C_GB_ZERO:    take = (gb_reg == '0);
            cssg_pkg::C_GA_NOT_ONE: take = (ga_reg != DW'(1));
            cssg_pkg::C_OUT_FULL:   take = !out_free;
            cssg_pkg::C_LAST_DONE:  take = (rep_reg == len_reg);
            default:                take = 1'b0;
        endcase
    end

    assign pc_next = take ? cw.target : pc_reg + 1'b1;

    // remainder unit request
    always_comb begin
        mreq.start    = 1'b0;
        mreq.dividend = idx_reg;
        mreq.divisor  = n_reg;
        case (cw.op)
            cssg_pkg::OP_MOD_IDX: begin
                mreq.start = 1'b1;
            end
            cssg_pkg::OP_MOD_STR: begin
                mreq.start    = 1'b1;
                mreq.dividend = strd_reg;
            end
            cssg_pkg::OP_MOD_CNT: begin
                mreq.start    = 1'b1;
                mreq.dividend = cnt_reg;
            end
            cssg_pkg::OP_MOD_GCD: begin
                mreq.start    = 1'b1;
                mreq.dividend = ga_reg;
                mreq.divisor  = gb_reg;
            end
            default: begin
                mreq.start = 1'b0;
            end
        endcase
    end

    cssg_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (mreq),
        .busy      (mod_busy),
        .remainder (mod_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lc_reg <= cssg_pkg::LIGHTS_RESET;
            sl_reg <= cssg_pkg::SUBSET_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                cssg_pkg::REG_LIGHT_COUNT:   lc_reg <= cfg_data;
                cssg_pkg::REG_SUBSET_LENGTH: sl_reg <= cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= cssg_pkg::ST_WAIT;
            idx_reg      <= '0;
            strd_reg     <= DW'(1);
            cnt_reg      <= '0;
            exh_reg      <= 1'b0;
            rep_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pc_reg <= pc_next;
            if (cw.op == cssg_pkg::OP_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (cw.op)
                cssg_pkg::OP_LOAD: begin
                    if (s_acc) begin
                        rep_reg <= '0;
                        if (s_tdata[0]) begin
                            idx_reg  <= '0;
                            strd_reg <= DW'(1);
                            cnt_reg  <= '0;
                            exh_reg  <= 1'b0;
                        end
                    end
                end
                cssg_pkg::OP_WB_IDX: idx_reg  <= mod_rem;
                cssg_pkg::OP_WB_STR: strd_reg <= mod_rem;
                cssg_pkg::OP_WB_CNT: cnt_reg  <= mod_rem;
                cssg_pkg::OP_COUNT: begin
                    cnt_reg <= (cnt_inc < n9) ? cnt_inc[DW-1:0] : '0;
                end
                cssg_pkg::OP_STRIDE: strd_reg <= str_wrap;
                cssg_pkg::OP_EXH: begin
                    if (strd_reg == DW'(1)) begin
                        exh_reg <= 1'b1;
                    end
                end
                cssg_pkg::OP_EMIT: begin
                    if (out_free) begin
                        idx_reg <= idx_adv;
                        rep_reg <= rep_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload and work registers
    always_ff @(posedge aclk) begin
        if (cw.op == cssg_pkg::OP_LOAD && s_acc) begin
            n_reg   <= n_clamp;
            len_reg <= len_clamp;
        end
        if (cw.op == cssg_pkg::OP_STRIDE) begin
            ga_reg <= n_reg;
            gb_reg <= str_wrap;
        end else if (cw.op == cssg_pkg::OP_WB_GCD) begin
            ga_reg <= gb_reg;
            gb_reg <= mod_rem;
        end
        if (cw.op == cssg_pkg::OP_EMIT && out_free) begin
            out_idx_reg  <= idx_reg;
            out_last_reg <= (LW'(rep_reg + 1'b1) == len_reg);
            out_exh_reg  <= exh_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_idx_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_exh_reg;

    // exhausted clears only on a restart request
    a_exh_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(exh_reg) |-> $past(s_acc && s_tdata[0]))
        else $error("exhausted flag dropped without restart");

    // index and stride stay reduced inside the generation loop
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg >= cssg_pkg::ST_COUNT) |-> (idx_reg < n_reg && strd_reg < n_reg))
        else $error("index or stride not below light count");

    // remainder unit is idle whenever a request can be taken
    a_mod_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !mod_busy)
        else $error("remainder unit busy while waiting for a request");

    // an item is emitted only from the emit step
    a_emit_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(pc_reg == cssg_pkg::ST_EMIT))
        else $error("output loaded outside the emit step");

endmodule
